### src/srot_pkg.sv
// Shared types and constants for the symmetric tensor rotation block.
package srot_pkg;

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int NUM_OUT    = 6;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_COL0 = 2'd0;
  localparam reg_idx_t REG_COL1 = 2'd1;
  localparam reg_idx_t REG_COL2 = 2'd2;

  typedef logic [1:0] col_idx_t;

  // Output component j = a[OUT_LEFT[j]] . s[OUT_RIGHT[j]]  (xx yy zz xy yz zx)
  localparam col_idx_t OUT_LEFT  [NUM_OUT] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
  localparam col_idx_t OUT_RIGHT [NUM_OUT] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctl_t;

endpackage

### src/srot_if.sv
// Stream interfaces: tensor in, rotated tensor out.
interface srot_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] in_xx;
  logic signed [DATA_WIDTH-1:0] in_yy;
  logic signed [DATA_WIDTH-1:0] in_zz;
  logic signed [DATA_WIDTH-1:0] in_xy;
  logic signed [DATA_WIDTH-1:0] in_yz;
  logic signed [DATA_WIDTH-1:0] in_zx;
  logic                         in_last;

  modport source (output valid, in_xx, in_yy, in_zz, in_xy, in_yz, in_zx, in_last,
                  input ready);
  modport sink   (input valid, in_xx, in_yy, in_zz, in_xy, in_yz, in_zx, in_last,
                  output ready);
endinterface

interface srot_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_xx;
  logic signed [DATA_WIDTH-1:0] out_yy;
  logic signed [DATA_WIDTH-1:0] out_zz;
  logic signed [DATA_WIDTH-1:0] out_xy;
  logic signed [DATA_WIDTH-1:0] out_yz;
  logic signed [DATA_WIDTH-1:0] out_zx;
  logic                         out_last;
  logic                         sat_flag;

  modport source (output valid, out_xx, out_yy, out_zz, out_xy, out_yz, out_zx, out_last,
                  sat_flag, input ready);
  modport sink   (input valid, out_xx, out_yy, out_zz, out_xy, out_yz, out_zx, out_last,
                  sat_flag, output ready);
endinterface

### src/srot_regs.sv
// APB register file holding the three frame matrix columns.
module srot_regs #(
  parameter int COEF_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srot_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [srot_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [srot_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [3*COEF_WIDTH-1:0]           col [3]
);

  localparam int COL_W = 3 * COEF_WIDTH;
  localparam int FRAC  = COEF_WIDTH - 2;

  srot_pkg::reg_idx_t sel;
  logic               wr;

  assign sel    = paddr[srot_pkg::APB_ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Reset to the identity: 1.0 on each diagonal entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      col[0] <= COL_W'(1) << FRAC;
      col[1] <= COL_W'(1) << (FRAC + COEF_WIDTH);
      col[2] <= COL_W'(1) << (FRAC + 2 * COEF_WIDTH);
    end else if (wr) begin
      unique case (sel)
        srot_pkg::REG_COL0: col[0] <= pwdata[COL_W-1:0];
        srot_pkg::REG_COL1: col[1] <= pwdata[COL_W-1:0];
        srot_pkg::REG_COL2: col[2] <= pwdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      srot_pkg::REG_COL0: prdata = srot_pkg::APB_DATA_W'(col[0]);
      srot_pkg::REG_COL1: prdata = srot_pkg::APB_DATA_W'(col[1]);
      srot_pkg::REG_COL2: prdata = srot_pkg::APB_DATA_W'(col[2]);
      default:            prdata = '0;
    endcase
  end

endmodule

### src/srot_col.sv
// First half: s_c = sigma * a_c, multiply stage then sum/round stage.
module srot_col #(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srot_pkg::beat_ctl_t           in_ctl,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  xx,
  input  logic signed [DATA_WIDTH-1:0]  yy,
  input  logic signed [DATA_WIDTH-1:0]  zz,
  input  logic signed [DATA_WIDTH-1:0]  xy,
  input  logic signed [DATA_WIDTH-1:0]  yz,
  input  logic signed [DATA_WIDTH-1:0]  zx,
  input  logic signed [COEF_WIDTH-1:0]  coef [3][3],
  output srot_pkg::beat_ctl_t           out_ctl,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH+2:0]  s [3][3]
);

  localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int FRAC   = COEF_WIDTH - 2;
  localparam int S_W    = DATA_WIDTH + 3;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (FRAC - 1);

  logic signed [DATA_WIDTH-1:0] row  [3][3];
  logic signed [PROD_W-1:0]     prod [3][3][3];
  logic signed [SUM_W-1:0]      sum  [3][3];
  logic signed [SUM_W-1:0]      shr  [3][3];
  srot_pkg::beat_ctl_t          ctl_a;
  logic                         en_a;
  logic                         en_b;

  assign en_b     = !out_ctl.valid || out_ready;
  assign en_a     = !ctl_a.valid || en_b;
  assign in_ready = en_a;

  // rows of sigma: (xx xy zx) (xy yy yz) (zx yz zz)
  always_comb begin
    row[0][0] = xx; row[0][1] = xy; row[0][2] = zx;
    row[1][0] = xy; row[1][1] = yy; row[1][2] = yz;
    row[2][0] = zx; row[2][1] = yz; row[2][2] = zz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      out_ctl <= '0;
    end else begin
      if (en_a) ctl_a <= in_ctl;
      if (en_b) out_ctl <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_ctl.valid) begin
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++)
            prod[c][r][k] <= row[r][k] * coef[c][k];
    end
  end

  // exact sum, then round half up to the input scale
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        sum[c][r] = SUM_W'(prod[c][r][0]) + SUM_W'(prod[c][r][1])
                  + SUM_W'(prod[c][r][2]) + RND;
        shr[c][r] = sum[c][r] >>> FRAC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && ctl_a.valid) begin
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++)
          s[c][r] <= shr[c][r][S_W-1:0];
    end
  end

endmodule

### src/srot_quad.sv
// Second half: a_i . s_c for the six outputs, multiply stage then sum/round/saturate.
module srot_quad #(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srot_pkg::beat_ctl_t           in_ctl,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH+2:0]  s [3][3],
  input  logic signed [COEF_WIDTH-1:0]  coef [3][3],
  output srot_pkg::beat_ctl_t           out_ctl,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  res [srot_pkg::NUM_OUT],
  output logic                          sat_flag
);

  localparam int S_W    = DATA_WIDTH + 3;
  localparam int PROD_W = S_W + COEF_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int FRAC   = COEF_WIDTH - 2;
  localparam int HI_W   = SUM_W - DATA_WIDTH + 1;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (FRAC - 1);
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MAX_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [PROD_W-1:0]   prod [srot_pkg::NUM_OUT][3];
  logic signed [SUM_W-1:0]    sum  [srot_pkg::NUM_OUT];
  logic signed [SUM_W-1:0]    shr  [srot_pkg::NUM_OUT];
  logic [HI_W-1:0]            hi   [srot_pkg::NUM_OUT];
  logic [srot_pkg::NUM_OUT-1:0] ovf;
  logic [DATA_WIDTH-1:0]      clip [srot_pkg::NUM_OUT];
  srot_pkg::beat_ctl_t        ctl_a;
  logic                       en_a;
  logic                       en_b;

  assign en_b     = !out_ctl.valid || out_ready;
  assign en_a     = !ctl_a.valid || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      out_ctl <= '0;
    end else begin
      if (en_a) ctl_a <= in_ctl;
      if (en_b) out_ctl <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_ctl.valid) begin
      for (int j = 0; j < srot_pkg::NUM_OUT; j++)
        for (int k = 0; k < 3; k++)
          prod[j][k] <= coef[srot_pkg::OUT_LEFT[j]][k] * s[srot_pkg::OUT_RIGHT[j]][k];
    end
  end

  // round, then clamp when the bits above the sign disagree
  always_comb begin
    for (int j = 0; j < srot_pkg::NUM_OUT; j++) begin
      sum[j]  = SUM_W'(prod[j][0]) + SUM_W'(prod[j][1]) + SUM_W'(prod[j][2]) + RND;
      shr[j]  = sum[j] >>> FRAC;
      hi[j]   = shr[j][SUM_W-1:DATA_WIDTH-1];
      ovf[j]  = !((&hi[j]) || !(|hi[j]));
      clip[j] = ovf[j] ? (shr[j][SUM_W-1] ? MAX_NEG : MAX_POS) : shr[j][DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && ctl_a.valid) begin
      for (int j = 0; j < srot_pkg::NUM_OUT; j++)
        res[j] <= clip[j];
      sat_flag <= |ovf;
    end
  end

endmodule

### src/sym_tensor_rotation.sv
// Top level of the symmetric tensor rotation block.
//
// Rotates one symmetric 3x3 tensor per beat: out = A^T * sigma * A.
// sigma arrives on the sink stream as xx yy zz xy yz zx plus a last mark;
// the rotated tensor leaves on the source stream, saturated per component,
// with last copied through and sat_flag set if any component clipped.
// A is held in three 60-bit column registers on the APB port at byte
// addresses 0, 8 and 16 (rows 0..2 of a column in 20-bit signed Q1.18
// fields); write them only while no beat is in flight.
// Throughput: one tensor per cycle while the receiver is ready, through
// four register stages (sigma*A multiply, sum/round, A^T*s multiply,
// sum/round/saturate).
// Each stage holds its own valid bit, so bubbles close up and input is
// taken while a finished result waits at the output.
// When the receiver stalls, the output holds and stages fill behind it;
// input ready drops only once every stage is full.
// Synchronous reset clears all valid bits and loads the identity matrix.
module sym_tensor_rotation #(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  srot_in_if.sink                           sigma,
  srot_out_if.source                        rotated,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srot_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [srot_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [srot_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [3*COEF_WIDTH-1:0]         col  [3];
  logic signed [COEF_WIDTH-1:0]    coef [3][3];
  logic signed [DATA_WIDTH+2:0]    s_mid [3][3];
  logic signed [DATA_WIDTH-1:0]    res  [srot_pkg::NUM_OUT];
  srot_pkg::beat_ctl_t             in_ctl;
  srot_pkg::beat_ctl_t             mid_ctl;
  srot_pkg::beat_ctl_t             out_ctl;
  logic                            mid_ready;
  logic                            out_sat;

  srot_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .col     (col)
  );

  // coef[c][r]: column c, row r
  always_comb begin
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        coef[c][r] = col[c][r*COEF_WIDTH +: COEF_WIDTH];
  end

  assign in_ctl.valid = sigma.valid;
  assign in_ctl.last  = sigma.in_last;

  srot_col #(
    .DATA_WIDTH (DATA_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_col (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (in_ctl),
    .in_ready  (sigma.ready),
    .xx        (sigma.in_xx),
    .yy        (sigma.in_yy),
    .zz        (sigma.in_zz),
    .xy        (sigma.in_xy),
    .yz        (sigma.in_yz),
    .zx        (sigma.in_zx),
    .coef      (coef),
    .out_ctl   (mid_ctl),
    .out_ready (mid_ready),
    .s         (s_mid)
  );

  srot_quad #(
    .DATA_WIDTH (DATA_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_quad (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (mid_ctl),
    .in_ready  (mid_ready),
    .s         (s_mid),
    .coef      (coef),
    .out_ctl   (out_ctl),
    .out_ready (rotated.ready),
    .res       (res),
    .sat_flag  (out_sat)
  );

  assign rotated.valid    = out_ctl.valid;
  assign rotated.out_last = out_ctl.last;
  assign rotated.sat_flag = out_sat;
  assign rotated.out_xx   = res[0];
  assign rotated.out_yy   = res[1];
  assign rotated.out_zz   = res[2];
  assign rotated.out_xy   = res[3];
  assign rotated.out_yz   = res[4];
  assign rotated.out_zx   = res[5];

endmodule

### tb/sv/sym_tensor_rotation_tb.sv
// Self-checking testbench for sym_tensor_rotation: streamed tensors checked against a predictor.
module sym_tensor_rotation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW           = 32;
  localparam int CW           = 20;
  localparam int FRAC         = CW - 2;
  localparam int PIPE_LATENCY = 4;
  localparam int IDLE_PCT     = 24;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 135;
  localparam int DRAIN_LIMIT  = 2000;
  localparam longint TIMEOUT_NS = 2_000_000;

  localparam int DMAX = 32'h7fff_ffff;
  localparam int DMIN = 32'h8000_0000;

  // Index of the first column register past the real ones; writes there are dropped.
  localparam srot_pkg::reg_idx_t REG_SPARE = 2'd3;

  // Result j = a[RES_LEFT[j]] . s[RES_RIGHT[j]], order xx yy zz xy yz zx
  localparam int RES_LEFT  [6] = '{0, 1, 2, 0, 1, 0};
  localparam int RES_RIGHT [6] = '{0, 1, 2, 1, 2, 2};

  typedef enum {MX_NEAR, MX_FULL, MX_PERM, MX_MAX, MX_MIN, MX_HALF} matrix_kind_t;

  typedef logic [2:0][63:0] matrix_regs_t;

  typedef struct packed {
    logic [5:0][DW-1:0] comp;
    logic               last;
  } tensor_t;

  typedef struct packed {
    logic [5:0][DW-1:0] comp;
    logic               last;
    logic               sat;
  } rot_result_t;

  class rotation_checker;
    logic [3*CW-1:0] col_regs [3];
    rot_result_t     pending_rotations [$];
    int              failures;
    string           comp_names [6];

    function new();
      col_regs[0] = 60'd1 << FRAC;
      col_regs[1] = 60'd1 << (FRAC + CW);
      col_regs[2] = 60'd1 << (FRAC + 2 * CW);
      comp_names  = '{"out_xx", "out_yy", "out_zz", "out_xy", "out_yz", "out_zx"};
      failures    = 0;
    endfunction

    function void write_reg(srot_pkg::reg_idx_t idx, logic [63:0] value);
      case (idx)
        srot_pkg::REG_COL0: col_regs[0] = value[3*CW-1:0];
        srot_pkg::REG_COL1: col_regs[1] = value[3*CW-1:0];
        srot_pkg::REG_COL2: col_regs[2] = value[3*CW-1:0];
        default: ;
      endcase
    endfunction

    // exact dot product, round half up back to the input scale
    function longint round_dot(longint m0, longint m1, longint m2,
                               longint v0, longint v1, longint v2);
      longint acc;
      acc = m0 * v0 + m1 * v1 + m2 * v2 + (longint'(1) <<< (FRAC - 1));
      return acc >>> FRAC;
    endfunction

    function rot_result_t rotate_tensor(tensor_t t);
      longint      a   [3][3];
      longint      sg  [3][3];
      longint      s   [3][3];
      longint      v;
      longint      hi;
      longint      lo;
      rot_result_t r;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      lo = -hi - 1;
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 3; i++) begin
          a[c][i] = $signed(col_regs[c][i*CW +: CW]);
        end
      end
      // full symmetric sigma, rows (xx xy zx) (xy yy yz) (zx yz zz)
      sg[0][0] = $signed(t.comp[0]); sg[0][1] = $signed(t.comp[3]); sg[0][2] = $signed(t.comp[5]);
      sg[1][0] = $signed(t.comp[3]); sg[1][1] = $signed(t.comp[1]); sg[1][2] = $signed(t.comp[4]);
      sg[2][0] = $signed(t.comp[5]); sg[2][1] = $signed(t.comp[4]); sg[2][2] = $signed(t.comp[2]);
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 3; i++) begin
          s[c][i] = round_dot(a[c][0], a[c][1], a[c][2], sg[i][0], sg[i][1], sg[i][2]);
        end
      end
      r.sat = 1'b0;
      for (int j = 0; j < 6; j++) begin
        v = round_dot(a[RES_LEFT[j]][0], a[RES_LEFT[j]][1], a[RES_LEFT[j]][2],
                      s[RES_RIGHT[j]][0], s[RES_RIGHT[j]][1], s[RES_RIGHT[j]][2]);
        if (v > hi) begin
          v = hi;
          r.sat = 1'b1;
        end else if (v < lo) begin
          v = lo;
          r.sat = 1'b1;
        end
        r.comp[j] = v[DW-1:0];
      end
      r.last = t.last;
      return r;
    endfunction

    function void note_tensor(tensor_t t);
      pending_rotations.push_back(rotate_tensor(t));
    endfunction

    function void report(string field, longint want, longint got);
      failures++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_rotation(rot_result_t got);
      rot_result_t want;
      if (pending_rotations.size() == 0) begin
        failures++;
        $error("rotated beat with no tensor pending");
        return;
      end
      want = pending_rotations.pop_front();
      for (int j = 0; j < 6; j++) begin
        if (got.comp[j] !== want.comp[j]) begin
          report(comp_names[j], $signed(want.comp[j]), $signed(got.comp[j]));
        end
      end
      if (got.last !== want.last) report("out_last", want.last, got.last);
      if (got.sat !== want.sat) report("sat_flag", want.sat, got.sat);
    endfunction
  endclass

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [srot_pkg::APB_ADDR_W-1:0] paddr;
  logic [srot_pkg::APB_DATA_W-1:0] pwdata;
  logic [srot_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  rotation_checker chk = new();

  srot_in_if  #(.DATA_WIDTH(DW)) sigma_if ();
  srot_out_if #(.DATA_WIDTH(DW)) rotated_if ();

  sym_tensor_rotation #(
    .DATA_WIDTH(DW),
    .COEF_WIDTH(CW)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .sigma   (sigma_if),
    .rotated (rotated_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("sym_tensor_rotation_tb failed");
    $finish;
  end

  // receiver: random stalls, calm stretches, and a long hold on each request
  initial begin
    rotated_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rotated_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        rotated_if.ready <= 1'b0;
      end else begin
        rotated_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    tensor_t t;
    if (!rst && sigma_if.valid && sigma_if.ready) begin
      t.comp[0] = sigma_if.in_xx;
      t.comp[1] = sigma_if.in_yy;
      t.comp[2] = sigma_if.in_zz;
      t.comp[3] = sigma_if.in_xy;
      t.comp[4] = sigma_if.in_yz;
      t.comp[5] = sigma_if.in_zx;
      t.last    = sigma_if.in_last;
      chk.note_tensor(t);
    end
  end

  always @(posedge clk) begin
    rot_result_t got;
    if (!rst && rotated_if.valid && rotated_if.ready) begin
      got.comp[0] = rotated_if.out_xx;
      got.comp[1] = rotated_if.out_yy;
      got.comp[2] = rotated_if.out_zz;
      got.comp[3] = rotated_if.out_xy;
      got.comp[4] = rotated_if.out_yz;
      got.comp[5] = rotated_if.out_zx;
      got.last    = rotated_if.out_last;
      got.sat     = rotated_if.sat_flag;
      chk.check_rotation(got);
    end
  end

  function automatic tensor_t tensor_of(int xx, int yy, int zz, int xy, int yz, int zx,
                                        bit last);
    tensor_t t;
    t.comp[0] = xx;
    t.comp[1] = yy;
    t.comp[2] = zz;
    t.comp[3] = xy;
    t.comp[4] = yz;
    t.comp[5] = zx;
    t.last    = last;
    return t;
  endfunction

  function automatic tensor_t make_tensor();
    tensor_t t;
    int      pick;
    int      val;
    for (int j = 0; j < 6; j++) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        val = $urandom;
      end else if (pick < 9) begin
        val = $urandom_range(131071) - 65536;
      end else begin
        case ($urandom_range(4))
          0: val = DMIN;
          1: val = DMAX;
          2: val = 0;
          3: val = -1;
          default: val = 1;
        endcase
      end
      t.comp[j] = val;
    end
    t.last = ($urandom_range(7) == 0);
    return t;
  endfunction

  // column registers, with random junk in the unused top bits
  function automatic matrix_regs_t make_matrix(matrix_kind_t kind);
    matrix_regs_t m;
    logic [CW-1:0] e [3];
    int           perm [3];
    int           v;
    perm[0] = $urandom_range(2);
    perm[1] = (perm[0] + 1 + $urandom_range(1)) % 3;
    perm[2] = 3 - perm[0] - perm[1];
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        case (kind)
          MX_FULL: v = $urandom;
          MX_PERM: v = (r == perm[c]) ? ($urandom_range(1) ? (1 << FRAC) : -(1 << FRAC)) : 0;
          MX_NEAR: v = ((r == c) ? (1 << FRAC) : 0) + $urandom_range(8191) - 4096;
          MX_MAX:  v = 32'h0007_ffff;
          MX_MIN:  v = 32'h0008_0000;
          default: v = 1 << (FRAC - 1);
        endcase
        e[r] = v[CW-1:0];
      end
      m[c] = {4'($urandom), e[2], e[1], e[0]};
    end
    return m;
  endfunction

  task automatic apb_write(srot_pkg::reg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    chk.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_matrix(matrix_kind_t kind);
    matrix_regs_t m;
    m = make_matrix(kind);
    apb_write(srot_pkg::REG_COL0, m[0]);
    apb_write(srot_pkg::REG_COL1, m[1]);
    apb_write(srot_pkg::REG_COL2, m[2]);
  endtask

  task automatic send_tensor(tensor_t t);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      sigma_if.valid <= 1'b0;
    end
    @(negedge clk);
    sigma_if.valid   <= 1'b1;
    sigma_if.in_xx   <= t.comp[0];
    sigma_if.in_yy   <= t.comp[1];
    sigma_if.in_zz   <= t.comp[2];
    sigma_if.in_xy   <= t.comp[3];
    sigma_if.in_yz   <= t.comp[4];
    sigma_if.in_zx   <= t.comp[5];
    sigma_if.in_last <= t.last;
    do @(posedge clk); while (!sigma_if.ready);
  endtask

  // drop valid and wait until every rotation has come back
  task automatic finish_phase();
    @(negedge clk);
    sigma_if.valid <= 1'b0;
    while (chk.pending_rotations.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  initial begin
    matrix_kind_t   phase_kinds [8];
    int             drain_cycles;
    phase_kinds = '{MX_NEAR, MX_FULL, MX_FULL, MX_PERM, MX_NEAR, MX_MAX, MX_MIN, MX_NEAR};

    sigma_if.valid   = 1'b0;
    sigma_if.in_xx   = '0;
    sigma_if.in_yy   = '0;
    sigma_if.in_zz   = '0;
    sigma_if.in_xy   = '0;
    sigma_if.in_yz   = '0;
    sigma_if.in_zx   = '0;
    sigma_if.in_last = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // identity matrix out of reset
    send_tensor(tensor_of(0, 0, 0, 0, 0, 0, 1'b0));
    send_tensor(tensor_of(DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b1));
    send_tensor(tensor_of(DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, 1'b0));
    send_tensor(tensor_of(DMAX, DMIN, DMAX, DMIN, DMAX, DMIN, 1'b1));
    send_tensor(tensor_of(1, -1, 2, -2, 3, -3, 1'b0));
    finish_phase();

    // every entry at -2.0: heavy saturation both ways
    load_matrix(MX_MIN);
    send_tensor(tensor_of(DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b0));
    send_tensor(tensor_of(DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, 1'b1));
    send_tensor(tensor_of(1, 1, 1, 1, 1, 1, 1'b0));
    send_tensor(tensor_of(0, 0, 0, 0, 0, 0, 1'b0));
    finish_phase();

    load_matrix(MX_MAX);
    send_tensor(tensor_of(DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b1));
    send_tensor(tensor_of(DMIN, 0, DMAX, 0, DMIN, 0, 1'b0));
    send_tensor(tensor_of(12345, -6789, 424242, -1, 77, -31337, 1'b0));
    finish_phase();

    // non-orthogonal, all entries 0.5: exact halves hit the rounding
    load_matrix(MX_HALF);
    send_tensor(tensor_of(1, 0, 0, 0, 0, 0, 1'b0));
    send_tensor(tensor_of(-1, 0, 0, 0, 0, 0, 1'b0));
    send_tensor(tensor_of(3, -3, 1, -1, 2, -2, 1'b1));
    send_tensor(tensor_of(DMAX, DMIN, DMAX, DMIN, DMAX, DMIN, 1'b0));
    finish_phase();

    // write past the last column register must leave the matrix alone
    apb_write(REG_SPARE, {$urandom, $urandom});
    send_tensor(tensor_of(7, -7, 100, -100, 5, 0, 1'b1));
    finish_phase();

    for (int p = 0; p < 8; p++) begin
      load_matrix(phase_kinds[p]);
      calm = (p == 2);
      if (p == 1 || p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_tensor(make_tensor());
      end
      finish_phase();
      calm = 1'b0;
    end

    drain_cycles = 0;
    while (chk.pending_rotations.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (chk.pending_rotations.size() != 0) begin
      chk.failures++;
      $error("%0d rotated beats never arrived", chk.pending_rotations.size());
    end
    if (chk.failures == 0) begin
      $display("sym_tensor_rotation_tb passed");
    end else begin
      $display("sym_tensor_rotation_tb failed");
    end
    $finish;
  end

endmodule

### files.f
src/srot_pkg.sv
src/srot_if.sv
src/srot_regs.sv
src/srot_col.sv
src/srot_quad.sv
src/sym_tensor_rotation.sv
tb/sv/sym_tensor_rotation_tb.sv
